FILE: hdl/qos_pkg.sv
// Shared types and constants of the quadrature odometry and speed block.
`default_nettype none
package qos_pkg;

  localparam logic [15:0] CPR_RESET   = 16'd6000;
  localparam logic [15:0] MS_PER_MIN  = 16'd60000;
  localparam logic [15:0] SPEED_MAX   = 16'h7FFF;
  localparam logic [15:0] SPEED_MIN   = 16'h8000;
  localparam logic        OP_INIT     = 1'b0;
  localparam logic        OP_SAMPLE   = 1'b1;

  typedef struct packed {
    logic        start;
    logic [15:0] diff;
    logic [31:0] elapsed;
  } spd_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] speed;
  } spd_rsp_t;

endpackage
`default_nettype wire

FILE: hdl/qos_if.sv
// Input and result channel interfaces of the quadrature odometry and speed block.
`default_nettype none
interface qos_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] count_a;
  logic [15:0] count_b;
  logic [31:0] now_ms;

  modport source (output valid, op, count_a, count_b, now_ms, input ready);
  modport sink   (input valid, op, count_a, count_b, now_ms, output ready);
endinterface

interface qos_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position_a;
  logic signed [31:0] position_b;
  logic signed [15:0] speed_a;
  logic signed [15:0] speed_b;
  logic               updated;

  modport source (output valid, position_a, position_b, speed_a, speed_b, updated,
                  input ready);
  modport sink   (input valid, position_a, position_b, speed_a, speed_b, updated,
                  output ready);
endinterface
`default_nettype wire

FILE: hdl/qos_speed_unit.sv
// Iterative speed unit: multiply, then restoring divide with saturation, one wheel at a time.
`default_nettype none
module qos_speed_unit
  import qos_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [15:0] cpr,
  input  wire spd_req_t    req,
  output spd_rsp_t         rsp
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [3:0]  cnt_r;
  logic        neg_r;
  logic        zero_r;
  logic [15:0] mag_r;
  logic [15:0] cpr_r;
  logic [31:0] elapsed_r;
  logic [31:0] num_r;
  logic [62:0] den_sh_r;
  logic [15:0] q_r;
  logic [47:0] den;
  logic        fits;
  logic [15:0] speed;

  assign den  = 48'(cpr_r) * 48'(elapsed_r);
  assign fits = {31'd0, num_r} >= den_sh_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (req.start) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_DIV;
      S_DIV:  if (cnt_r == 4'd0) state_nxt = S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (req.start) begin
          neg_r     <= req.diff[15];
          mag_r     <= req.diff[15] ? (~req.diff + 16'd1) : req.diff;
          elapsed_r <= req.elapsed;
          cpr_r     <= cpr;
        end
      end
      S_MUL: begin
        num_r    <= 32'(mag_r) * 32'(MS_PER_MIN);
        den_sh_r <= {den[47:0], 15'd0};
        zero_r   <= (den == 48'd0);
        q_r      <= 16'd0;
        cnt_r    <= 4'd15;
      end
      S_DIV: begin
        if (fits) begin
          num_r <= num_r - den_sh_r[31:0];
        end
        q_r      <= {q_r[14:0], fits};
        den_sh_r <= den_sh_r >> 1;
        cnt_r    <= cnt_r - 4'd1;
      end
      default: ;
    endcase
  end

  // q_r[15] set means the quotient reached 32768: saturate.
  always_comb begin
    if (zero_r) begin
      speed = 16'd0;
    end else if (neg_r) begin
      speed = q_r[15] ? SPEED_MIN : (~q_r + 16'd1);
    end else begin
      speed = q_r[15] ? SPEED_MAX : q_r;
    end
  end

  assign rsp.done  = (state_r == S_DONE);
  assign rsp.speed = speed;

endmodule
`default_nettype wire

FILE: hdl/quadrature_odometry_speed.sv
// Top level: two-wheel quadrature odometry and rev/min speed measurement.
// Init and zero-elapsed samples go from accept through the output state to result valid; other
//   samples make two passes (wheel A, then wheel B) through one multiply plus 16-step divider.
// Flow: one transaction at a time; next input taken once the result is registered,
//   later while an earlier result still waits at the output.
// Reset: synchronous active-low; clears baseline, positions and speeds, counts_per_rev = 6000.
`default_nettype none
module quadrature_odometry_speed
  import qos_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  qos_in_if.sink           in_ch,
  qos_out_if.source        out_ch
);

  localparam logic [1:0] T_IDLE  = 2'd0;
  localparam logic [1:0] T_RUN_A = 2'd1;
  localparam logic [1:0] T_RUN_B = 2'd2;
  localparam logic [1:0] T_OUT   = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [15:0] cpr_r;
  logic [15:0] base_a_r, base_b_r;
  logic [31:0] base_tick_r;
  logic [31:0] odo_a_r, odo_b_r;
  logic [15:0] rpm_a_r, rpm_b_r;
  logic [15:0] da_r, db_r;
  logic [31:0] elapsed_r;
  logic        upd_r;
  logic        start_r;
  logic        out_valid_r;
  logic        accept;
  logic [31:0] elapsed;
  logic [15:0] da, db;
  spd_req_t    req;
  spd_rsp_t    rsp;

  assign accept  = in_ch.valid && in_ch.ready;
  assign elapsed = in_ch.now_ms - base_tick_r;
  assign da      = in_ch.count_a - base_a_r;
  assign db      = in_ch.count_b - base_b_r;

  assign req.start   = start_r;
  assign req.diff    = (state_r == T_RUN_B) ? db_r : da_r;
  assign req.elapsed = elapsed_r;

  qos_speed_unit u_speed (
    .clk   (clk),
    .rst_n (rst_n),
    .cpr   (cpr_r),
    .req   (req),
    .rsp   (rsp)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      T_IDLE: begin
        if (accept) begin
          if (in_ch.op == OP_SAMPLE && elapsed != 32'd0) state_nxt = T_RUN_A;
          else state_nxt = T_OUT;
        end
      end
      T_RUN_A: if (rsp.done) state_nxt = T_RUN_B;
      T_RUN_B: if (rsp.done) state_nxt = T_OUT;
      T_OUT:   if (!out_valid_r || out_ch.ready) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      cpr_r       <= CPR_RESET;
      base_a_r    <= 16'd0;
      base_b_r    <= 16'd0;
      base_tick_r <= 32'd0;
      odo_a_r     <= 32'd0;
      odo_b_r     <= 32'd0;
      rpm_a_r     <= 16'd0;
      rpm_b_r     <= 16'd0;
      upd_r       <= 1'b0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= (state_nxt != state_r) && (state_nxt == T_RUN_A || state_nxt == T_RUN_B);
      if (cfg_we) cpr_r <= cfg_wdata;
      if (state_r == T_OUT && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        T_IDLE: begin
          if (accept) begin
            if (in_ch.op == OP_INIT) begin
              base_a_r    <= in_ch.count_a;
              base_b_r    <= in_ch.count_b;
              base_tick_r <= in_ch.now_ms;
              odo_a_r     <= 32'd0;
              odo_b_r     <= 32'd0;
              rpm_a_r     <= 16'd0;
              rpm_b_r     <= 16'd0;
              upd_r       <= 1'b1;
            end else if (elapsed != 32'd0) begin
              odo_a_r     <= odo_a_r + {{16{da[15]}}, da};
              odo_b_r     <= odo_b_r + {{16{db[15]}}, db};
              base_a_r    <= in_ch.count_a;
              base_b_r    <= in_ch.count_b;
              base_tick_r <= in_ch.now_ms;
              upd_r       <= 1'b1;
            end else begin
              upd_r <= 1'b0;
            end
          end
        end
        T_RUN_A: begin
          if (rsp.done) rpm_a_r <= rsp.speed;
        end
        T_RUN_B: begin
          if (rsp.done) rpm_b_r <= rsp.speed;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == T_IDLE && accept) begin
      da_r      <= da;
      db_r      <= db;
      elapsed_r <= elapsed;
    end
  end

  logic signed [31:0] pos_a_r, pos_b_r;
  logic signed [15:0] spd_a_r, spd_b_r;
  logic               upd_out_r;

  always_ff @(posedge clk) begin
    if (state_r == T_OUT && (!out_valid_r || out_ch.ready)) begin
      pos_a_r   <= odo_a_r;
      pos_b_r   <= odo_b_r;
      spd_a_r   <= rpm_a_r;
      spd_b_r   <= rpm_b_r;
      upd_out_r <= upd_r;
    end
  end

  assign in_ch.ready       = (state_r == T_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.position_a = pos_a_r;
  assign out_ch.position_b = pos_b_r;
  assign out_ch.speed_a    = spd_a_r;
  assign out_ch.speed_b    = spd_b_r;
  assign out_ch.updated    = upd_out_r;

  a_start_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> (state_r == T_RUN_A || state_r == T_RUN_B))
    else $error("speed unit started outside a run state");

  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> (state_r == T_RUN_A || state_r == T_RUN_B))
    else $error("speed unit finished outside a run state");

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == T_OUT))
    else $error("result registered outside output state");

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// Testbench for quadrature_odometry_speed: predicted position and speed checks under random flow control.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qos_pkg::*;

  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int DRAIN_CYCLES  = 64;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_ITEMS   = 250;

  typedef struct {
    logic signed [31:0] position_a;
    logic signed [31:0] position_b;
    logic signed [15:0] speed_a;
    logic signed [15:0] speed_b;
    logic               updated;
  } odo_readout_t;

  class odometry_scoreboard;
    logic [15:0]  cpr;
    logic [15:0]  base_a;
    logic [15:0]  base_b;
    logic [31:0]  base_tick;
    logic [31:0]  odo_a;
    logic [31:0]  odo_b;
    logic [15:0]  rpm_a;
    logic [15:0]  rpm_b;
    odo_readout_t pending_readouts[$];
    int           errors;

    function new();
      cpr       = CPR_RESET;
      base_a    = '0;
      base_b    = '0;
      base_tick = '0;
      odo_a     = '0;
      odo_b     = '0;
      rpm_a     = '0;
      rpm_b     = '0;
      errors    = 0;
    endfunction

    function void set_cpr(logic [15:0] value);
      cpr = value;
    endfunction

    function int pending();
      return pending_readouts.size();
    endfunction

    // rev/min from a signed count delta, truncated toward zero, saturated
    function logic [15:0] rpm_of(logic [15:0] delta, logic [31:0] elapsed);
      logic [63:0] mag;
      logic [63:0] den;
      logic [63:0] q;
      mag = delta[15] ? 64'(17'h10000 - {1'b0, delta}) : 64'(delta);
      den = 64'(cpr) * 64'(elapsed);
      if (den == 64'd0) begin
        return 16'd0;
      end
      q = (mag * 64'(MS_PER_MIN)) / den;
      if (delta[15]) begin
        if (q > 64'(SPEED_MIN)) begin
          q = 64'(SPEED_MIN);
        end
        return ~q[15:0] + 16'd1;
      end
      if (q > 64'(SPEED_MAX)) begin
        q = 64'(SPEED_MAX);
      end
      return q[15:0];
    endfunction

    function void note_input(logic op, logic [15:0] ca, logic [15:0] cb, logic [31:0] now);
      odo_readout_t exp;
      logic [31:0]  elapsed;
      logic [15:0]  da;
      logic [15:0]  db;
      exp.updated = 1'b0;
      if (op == OP_INIT) begin
        base_a    = ca;
        base_b    = cb;
        base_tick = now;
        odo_a     = '0;
        odo_b     = '0;
        rpm_a     = '0;
        rpm_b     = '0;
        exp.updated = 1'b1;
      end else begin
        elapsed = now - base_tick;
        if (elapsed != 32'd0) begin
          da        = ca - base_a;
          db        = cb - base_b;
          odo_a     = odo_a + {{16{da[15]}}, da};
          odo_b     = odo_b + {{16{db[15]}}, db};
          rpm_a     = rpm_of(da, elapsed);
          rpm_b     = rpm_of(db, elapsed);
          base_a    = ca;
          base_b    = cb;
          base_tick = now;
          exp.updated = 1'b1;
        end
      end
      exp.position_a = odo_a;
      exp.position_b = odo_b;
      exp.speed_a    = rpm_a;
      exp.speed_b    = rpm_b;
      pending_readouts.push_back(exp);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) begin
        $display("ERROR @%0t: %s", $realtime, msg);
      end
    endtask

    task check_result(odo_readout_t got);
      odo_readout_t exp;
      if (pending_readouts.size() == 0) begin
        report("result transaction with no pending input");
        return;
      end
      exp = pending_readouts.pop_front();
      if (got.position_a !== exp.position_a) begin
        report($sformatf("position_a got %0d exp %0d", got.position_a, exp.position_a));
      end
      if (got.position_b !== exp.position_b) begin
        report($sformatf("position_b got %0d exp %0d", got.position_b, exp.position_b));
      end
      if (got.speed_a !== exp.speed_a) begin
        report($sformatf("speed_a got %0d exp %0d", got.speed_a, exp.speed_a));
      end
      if (got.speed_b !== exp.speed_b) begin
        report($sformatf("speed_b got %0d exp %0d", got.speed_b, exp.speed_b));
      end
      if (got.updated !== exp.updated) begin
        report($sformatf("updated got %b exp %b", got.updated, exp.updated));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        no_idle;
  int          stall_reqs;
  int          cycle_cnt;

  qos_in_if  in_if();
  qos_out_if out_if();

  odometry_scoreboard sb = new();

  quadrature_odometry_speed u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Mismatches found");
    $finish;
  end

  function int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function logic [15:0] pick_delta();
    int r;
    logic [15:0] mag;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      mag = 16'($urandom_range(0, 2000));
    end else if (r < 90) begin
      mag = 16'($urandom_range(0, 32767));
    end else begin
      return 16'($urandom);
    end
    return $urandom_range(0, 1) ? mag : ~mag + 16'd1;
  endfunction

  function logic [31:0] pick_elapsed();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)  return 32'd0;
    if (r < 80) return 32'($urandom_range(1, 100));
    if (r < 95) return 32'($urandom_range(100, 5000));
    return 32'($urandom);
  endfunction

  task send_snapshot(logic op, logic [15:0] ca, logic [15:0] cb, logic [31:0] now);
    int gap;
    gap = no_idle ? 0 : idle_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.op      <= op;
    in_if.count_a <= ca;
    in_if.count_b <= cb;
    in_if.now_ms  <= now;
    do @(posedge clk); while (!in_if.ready);
    sb.note_input(op, ca, cb, now);
  endtask

  task wait_drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task write_cpr(logic [15:0] value);
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_cpr(value);
  endtask

  // result side: random backpressure plus one long hold-off on request
  initial begin : result_sink
    int hold_left;
    int stall_seen;
    int gap_left;
    odo_readout_t got;
    hold_left  = 0;
    stall_seen = 0;
    gap_left   = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        got.position_a = out_if.position_a;
        got.position_b = out_if.position_b;
        got.speed_a    = out_if.speed_a;
        got.speed_b    = out_if.speed_b;
        got.updated    = out_if.updated;
        sb.check_result(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_seen != stall_reqs) begin
        stall_seen   = stall_reqs;
        hold_left    = HOLD_CYCLES;
        out_if.ready <= 1'b0;
      end else if (no_idle) begin
        out_if.ready <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        out_if.ready <= 1'b0;
      end else begin
        gap_left     = idle_len();
        out_if.ready <= (gap_left == 0);
      end
    end
  end

  initial begin : stimulus
    logic [15:0] cpr_set[RANDOM_PHASES];
    logic [15:0] cur_a;
    logic [15:0] cur_b;
    logic [31:0] cur_now;
    logic        op;
    int          r;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    no_idle       <= 1'b0;
    stall_reqs    <= 0;
    in_if.valid   <= 1'b0;
    in_if.op      <= OP_INIT;
    in_if.count_a <= '0;
    in_if.count_b <= '0;
    in_if.now_ms  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset state, init, zero elapsed, counter and tick wrap, saturation
    send_snapshot(OP_SAMPLE, 16'h0000, 16'h0000, 32'd0);
    send_snapshot(OP_SAMPLE, 16'd600,  16'hFFFF, 32'd10);
    send_snapshot(OP_INIT,   16'h1234, 16'hFFFF, 32'd100);
    send_snapshot(OP_SAMPLE, 16'h29A4, 16'hF447, 32'd1100);
    send_snapshot(OP_SAMPLE, 16'h29A4, 16'hF447, 32'd1100);
    send_snapshot(OP_SAMPLE, 16'hA9A3, 16'h7447, 32'd1101);
    send_snapshot(OP_SAMPLE, 16'hA9A3, 16'h7447, 32'h0000_0000);
    send_snapshot(OP_SAMPLE, 16'hA9A4, 16'h7446, 32'hFFFF_FFFF);
    send_snapshot(OP_INIT,   16'hFFFF, 16'h0000, 32'hFFFF_FFF0);
    send_snapshot(OP_SAMPLE, 16'h0009, 16'hFFF7, 32'h0000_0010);
    send_snapshot(OP_INIT,   16'h0000, 16'h0000, 32'd0);
    send_snapshot(OP_SAMPLE, 16'hFFFF, 16'h0001, 32'd1);
    send_snapshot(OP_INIT,   16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_snapshot(OP_SAMPLE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_snapshot(OP_SAMPLE, 16'h7FFE, 16'h8000, 32'h0000_0000);
    write_cpr(16'd1);
    send_snapshot(OP_SAMPLE, 16'h8000, 16'h7FFF, 32'd1);
    send_snapshot(OP_SAMPLE, 16'h8001, 16'h7FFE, 32'd1000);
    write_cpr(16'hFFFF);
    send_snapshot(OP_SAMPLE, 16'h0001, 16'hFFFF, 32'd1001);
    send_snapshot(OP_SAMPLE, 16'h7FFF, 16'h8000, 32'd1002);
    write_cpr(16'd0);
    send_snapshot(OP_SAMPLE, 16'h1000, 16'h2000, 32'd1500);
    send_snapshot(OP_INIT,   16'h5555, 16'hAAAA, 32'h5555_AAAA);
    send_snapshot(OP_SAMPLE, 16'hAAAA, 16'h5555, 32'hAAAA_5555);

    cpr_set[0] = 16'd1;
    cpr_set[1] = 16'hFFFF;
    cpr_set[2] = CPR_RESET;
    cpr_set[3] = 16'd0;
    cpr_set[4] = 16'($urandom_range(2, 64));
    cpr_set[5] = 16'($urandom_range(1, 65535));
    cpr_set[6] = 16'($urandom_range(100, 10000));

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_cpr(cpr_set[p]);
      no_idle <= (p == 2);
      if (p == 1) begin
        stall_reqs <= stall_reqs + 1;
      end
      cur_a   = 16'($urandom);
      cur_b   = 16'($urandom);
      cur_now = 32'($urandom);
      send_snapshot(OP_INIT, cur_a, cur_b, cur_now);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 4 && i == PHASE_ITEMS / 2) begin
          wait_drain();
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
          cur_a   = cur_a + pick_delta();
          cur_b   = cur_b + pick_delta();
          cur_now = cur_now + pick_elapsed();
          send_snapshot(OP_INIT, cur_a, cur_b, cur_now);
        end else if (r < 12) begin
          op      = 1'($urandom_range(0, 1));
          cur_a   = 16'($urandom);
          cur_b   = 16'($urandom);
          cur_now = 32'($urandom);
          send_snapshot(op, cur_a, cur_b, cur_now);
        end else begin
          cur_a   = cur_a + pick_delta();
          cur_b   = cur_b + pick_delta();
          cur_now = cur_now + pick_elapsed();
          send_snapshot(OP_SAMPLE, cur_a, cur_b, cur_now);
        end
      end
    end

    wait_drain();
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
